>>> rtl/hkv_pkg.sv
// shared types, constants and helpers for the key/value table with expiry
// no dependencies
package hkv_pkg;

    // slot count must stay a power of two: home slot and wrap use the low hash bits
    localparam int SLOT_COUNT = 1024;
    localparam int KEY_BYTES  = 8;
    localparam int IDX_W      = $clog2(SLOT_COUNT);
    localparam int PRB_W      = $clog2(SLOT_COUNT + 1);
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
    localparam int LEN_W      = 4;
    localparam int KEY_W      = 64;
    localparam int HASH_W     = 32;
    localparam int VAL_W      = 32;
    localparam int TIME_W     = 63;
    localparam int OP_W       = 4;

    localparam logic [HASH_W-1:0] HASH_SEED = 32'd5381;

    typedef enum logic [OP_W-1:0] {
        OP_SET        = 4'd0,
        OP_GET        = 4'd1,
        OP_DEL        = 4'd2,
        OP_SET_EXPIRY = 4'd3,
        OP_GET_EXPIRY = 4'd4,
        OP_SET_NX     = 4'd5,
        OP_SET_XX     = 4'd6,
        OP_CAS        = 4'd7,
        OP_TOUCH      = 4'd8,
        OP_EVICT      = 4'd9,
        OP_CLEAR      = 4'd10
    } op_t;

    typedef enum logic [1:0] {
        ST_MISS = 2'd0,
        ST_HIT  = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        FIND_HIT,
        FIND_EMPTY,
        FIND_FULL
    } find_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_HASH,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_CLR,
        B_IDLE,
        B_RD,
        B_CHK,
        B_EXEC,
        B_SRD,
        B_SCHK,
        B_RESP
    } back_state_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  key;
        logic [LEN_W-1:0]  len;
        logic [HASH_W-1:0] hash;
        logic [VAL_W-1:0]  nval;
        logic [VAL_W-1:0]  xval;
        logic [TIME_W-1:0] texp;
        logic [TIME_W-1:0] now;
    } req_t;

    typedef struct packed {
        logic              used;
        logic              live;
        logic [KEY_W-1:0]  key;
        logic [LEN_W-1:0]  len;
        logic [HASH_W-1:0] hash;
        logic [VAL_W-1:0]  value;
        logic [TIME_W-1:0] expiry;
    } slot_t;

    // h * 33 + b as shift and add
    function automatic logic [HASH_W-1:0] hash_step(input logic [HASH_W-1:0] h,
                                                    input logic [7:0] b);
        hash_step = (h << 5) + h + {{(HASH_W-8){1'b0}}, b};
    endfunction

endpackage

>>> rtl/hkv_front.sv
// front part: accepts a request, normalizes the key and hashes it one byte a cycle
// depends on hkv_pkg
module hkv_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [hkv_pkg::OP_W-1:0]    opcode,
    input  logic [hkv_pkg::KEY_W-1:0]   key_bytes,
    input  logic [hkv_pkg::LEN_W-1:0]   key_length,
    input  logic [hkv_pkg::VAL_W-1:0]   new_value,
    input  logic [hkv_pkg::VAL_W-1:0]   expected_value,
    input  logic [hkv_pkg::TIME_W-1:0]  expiry_time,
    input  logic [hkv_pkg::TIME_W-1:0]  now_us,
    input  logic                        q_full,
    output logic                        q_push,
    output hkv_pkg::req_t               q_item
);
    import hkv_pkg::*;

    front_state_t      state_reg, state_next;
    req_t              req_reg, req_next;
    logic [LEN_W-1:0]  cnt_reg, cnt_next;
    logic [LEN_W-1:0]  len_c;
    logic [KEY_W-1:0]  key_c;
    logic              accept;

    assign accept   = (state_reg == F_IDLE) && in_valid;
    assign in_stall = (state_reg != F_IDLE);
    assign q_push   = (state_reg == F_PUSH) && !q_full;
    assign q_item   = req_reg;

    always_comb
    begin
        len_c = (key_length > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : key_length;
        for (int b = 0; b < 8; b++)
        begin
            key_c[b*8 +: 8] = (b < int'(len_c)) ? key_bytes[b*8 +: 8] : 8'd0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: if (accept) state_next = F_HASH;
            F_HASH: if (cnt_reg == req_reg.len) state_next = F_PUSH;
            F_PUSH: if (!q_full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        req_next = req_reg;
        cnt_next = cnt_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    req_next.op   = opcode;
                    req_next.key  = key_c;
                    req_next.len  = len_c;
                    req_next.hash = HASH_SEED;
                    req_next.nval = new_value;
                    req_next.xval = expected_value;
                    req_next.texp = expiry_time;
                    req_next.now  = now_us;
                    cnt_next      = '0;
                end
            end
            F_HASH:
            begin
                if (cnt_reg != req_reg.len)
                begin
                    req_next.hash = hash_step(req_reg.hash, req_reg.key[cnt_reg[2:0]*8 +: 8]);
                    cnt_next      = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                req_next = req_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        cnt_reg <= cnt_next;
    end

endmodule

>>> rtl/hkv_queue.sv
// two-entry request queue between front and back
// depends on hkv_pkg
module hkv_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  hkv_pkg::req_t push_item,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output hkv_pkg::req_t pop_item
);
    import hkv_pkg::*;

    req_t        entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_push, do_pop;

    assign full     = (count_reg == 2'd2);
    assign valid    = (count_reg != 2'd0);
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;
    assign pop_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> rtl/hkv_back.sv
// back part: slot memory, linear probe, operation execution, table scans, result register
// depends on hkv_pkg
module hkv_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  hkv_pkg::req_t               q_item,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  status,
    output logic [hkv_pkg::VAL_W-1:0]   read_value,
    output logic [hkv_pkg::TIME_W-1:0]  read_expiry,
    output logic [hkv_pkg::CNT_W-1:0]   live_count,
    output logic [hkv_pkg::CNT_W-1:0]   evicted_count
);
    import hkv_pkg::*;

    slot_t             mem [SLOT_COUNT];
    slot_t             rd_reg;
    logic              mem_we, mem_re;
    logic [IDX_W-1:0]  mem_addr;
    slot_t             mem_wdata;

    back_state_t       state_reg, state_next;
    req_t              req_reg, req_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [PRB_W-1:0]  probe_reg, probe_next;
    find_t             find_reg, find_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  ev_reg, ev_next;

    logic              out_valid_reg, out_valid_next;
    logic [1:0]        status_reg, status_next;
    logic [VAL_W-1:0]  rval_reg, rval_next;
    logic [TIME_W-1:0] rexp_reg, rexp_next;
    logic [CNT_W-1:0]  live_reg, live_next;
    logic [CNT_W-1:0]  evc_reg, evc_next;

    logic              out_free;
    logic              key_match;
    logic              expd;
    logic              hit;
    logic              last_idx;
    logic              last_probe;

    assign out_free   = !out_valid_reg || !out_stall;
    assign key_match  = (rd_reg.hash == req_reg.hash) && (rd_reg.len == req_reg.len)
                        && (rd_reg.key == req_reg.key);
    assign expd       = (rd_reg.expiry != '0) && (req_reg.now >= rd_reg.expiry);
    assign hit        = (find_reg == FIND_HIT);
    assign last_idx   = (idx_reg == IDX_W'(SLOT_COUNT - 1));
    assign last_probe = (probe_reg == PRB_W'(SLOT_COUNT - 1));

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign read_value    = rval_reg;
    assign read_expiry   = rexp_reg;
    assign live_count    = live_reg;
    assign evicted_count = evc_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_CLR:  if (last_idx) state_next = B_IDLE;
            B_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_item.op == OP_EVICT || q_item.op == OP_CLEAR)
                        state_next = B_SRD;
                    else
                        state_next = B_RD;
                end
            end
            B_RD:   state_next = B_CHK;
            B_CHK:
            begin
                if (!rd_reg.used || key_match || last_probe)
                    state_next = B_EXEC;
                else
                    state_next = B_RD;
            end
            B_EXEC: if (out_free) state_next = B_IDLE;
            B_SRD:  state_next = B_SCHK;
            B_SCHK: state_next = last_idx ? B_RESP : B_SRD;
            B_RESP: if (out_free) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = idx_reg;
        mem_wdata   = rd_reg;
        q_pop       = 1'b0;
        req_next    = req_reg;
        idx_next    = idx_reg;
        probe_next  = probe_reg;
        find_next   = find_reg;
        cnt_next    = cnt_reg;
        ev_next     = ev_reg;
        status_next = status_reg;
        rval_next   = rval_reg;
        rexp_next   = rexp_reg;
        live_next   = live_reg;
        evc_next    = evc_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            B_CLR:
            begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                idx_next  = idx_reg + 1'b1;
            end
            B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    req_next   = q_item;
                    probe_next = '0;
                    ev_next    = '0;
                    if (q_item.op == OP_EVICT || q_item.op == OP_CLEAR)
                        idx_next = '0;
                    else
                        idx_next = q_item.hash[IDX_W-1:0];
                end
            end
            B_RD, B_SRD:
            begin
                mem_re = 1'b1;
            end
            B_CHK:
            begin
                if (!rd_reg.used)
                begin
                    find_next = FIND_EMPTY;
                end
                else if (key_match)
                begin
                    find_next = FIND_HIT;
                end
                else if (last_probe)
                begin
                    find_next = FIND_FULL;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    probe_next = probe_reg + 1'b1;
                end
            end
            B_EXEC:
            begin
                if (out_free)
                begin
                    status_next = ST_MISS;
                    rval_next   = '0;
                    rexp_next   = '0;
                    evc_next    = '0;
                    case (req_reg.op) inside
                        OP_SET, OP_SET_NX:
                        begin
                            if (hit)
                            begin
                                if (!(req_reg.op == OP_SET_NX && rd_reg.live && !expd))
                                begin
                                    mem_wdata.live   = 1'b1;
                                    mem_wdata.value  = req_reg.nval;
                                    mem_wdata.expiry = '0;
                                    mem_we           = 1'b1;
                                    if (!rd_reg.live)
                                        cnt_next = cnt_reg + 1'b1;
                                    status_next = ST_HIT;
                                end
                            end
                            else if (find_reg == FIND_EMPTY)
                            begin
                                mem_wdata.used   = 1'b1;
                                mem_wdata.live   = 1'b1;
                                mem_wdata.key    = req_reg.key;
                                mem_wdata.len    = req_reg.len;
                                mem_wdata.hash   = req_reg.hash;
                                mem_wdata.value  = req_reg.nval;
                                mem_wdata.expiry = '0;
                                mem_we           = 1'b1;
                                cnt_next         = cnt_reg + 1'b1;
                                status_next      = ST_HIT;
                            end
                            else
                            begin
                                status_next = ST_FULL;
                            end
                        end
                        OP_GET, OP_SET_EXPIRY, OP_GET_EXPIRY:
                        begin
                            if (hit && rd_reg.live && rd_reg.value != '0)
                            begin
                                if (expd)
                                begin
                                    mem_wdata.live = 1'b0;
                                    mem_we         = 1'b1;
                                    cnt_next       = cnt_reg - 1'b1;
                                end
                                else
                                begin
                                    status_next = ST_HIT;
                                    if (req_reg.op == OP_GET)
                                        rval_next = rd_reg.value;
                                    else if (req_reg.op == OP_SET_EXPIRY)
                                    begin
                                        mem_wdata.expiry = req_reg.texp;
                                        mem_we           = 1'b1;
                                    end
                                    else
                                        rexp_next = rd_reg.expiry;
                                end
                            end
                        end
                        OP_DEL, OP_SET_XX:
                        begin
                            if (hit && rd_reg.live)
                            begin
                                mem_we = 1'b1;
                                if (expd || req_reg.op == OP_DEL)
                                begin
                                    mem_wdata.live = 1'b0;
                                    cnt_next       = cnt_reg - 1'b1;
                                end
                                else
                                begin
                                    mem_wdata.value  = req_reg.nval;
                                    mem_wdata.expiry = '0;
                                end
                                if (!expd)
                                    status_next = ST_HIT;
                            end
                        end
                        OP_CAS, OP_TOUCH:
                        begin
                            if (!(req_reg.op == OP_TOUCH && req_reg.xval == '0) && hit
                                && rd_reg.live && rd_reg.value == req_reg.xval)
                            begin
                                mem_we = 1'b1;
                                if (expd)
                                begin
                                    mem_wdata.live = 1'b0;
                                    cnt_next       = cnt_reg - 1'b1;
                                end
                                else
                                begin
                                    status_next = ST_HIT;
                                    if (req_reg.op == OP_TOUCH)
                                        mem_wdata.expiry = req_reg.texp;
                                    else if (req_reg.nval != '0)
                                        mem_wdata.value = req_reg.nval;
                                    else
                                    begin
                                        mem_wdata.live = 1'b0;
                                        cnt_next       = cnt_reg - 1'b1;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            status_next = ST_MISS;
                        end
                    endcase
                    live_next      = cnt_next;
                    out_valid_next = 1'b1;
                end
            end
            B_SCHK:
            begin
                if (rd_reg.used && rd_reg.live && (req_reg.op == OP_CLEAR || expd))
                begin
                    mem_wdata.live = 1'b0;
                    mem_we         = 1'b1;
                    cnt_next       = cnt_reg - 1'b1;
                    if (req_reg.op == OP_EVICT)
                        ev_next = ev_reg + 1'b1;
                end
                idx_next = idx_reg + 1'b1;
            end
            B_RESP:
            begin
                if (out_free)
                begin
                    status_next    = ST_HIT;
                    rval_next      = '0;
                    rexp_next      = '0;
                    live_next      = cnt_reg;
                    evc_next       = ev_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        if (mem_re)
            rd_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLR;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        probe_reg  <= probe_next;
        find_reg   <= find_next;
        ev_reg     <= ev_next;
        status_reg <= status_next;
        rval_reg   <= rval_next;
        rexp_reg   <= rexp_next;
        live_reg   <= live_next;
        evc_reg    <= evc_next;
    end

endmodule

>>> rtl/hash_table_key_value_with_expiry.sv
// Key/value table with expiry: 1024 slots, open addressing with linear probing.
// A request is hashed one key byte per cycle in the front, passes a two-entry
// queue, then the back probes the slot memory with a read and a check for each
// slot visited, then writes back the slot where the operation changes it and
// registers the result. Evict and clear scan every slot. The slot memory is
// single-port. After reset the back clears the used marks in a pass over all
// 1024 slots before it takes the first request; requests may be accepted into
// the queue meanwhile. Results wait in an output register.
// depends on hkv_pkg, hkv_front, hkv_queue, hkv_back
module hash_table_key_value_with_expiry (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [hkv_pkg::OP_W-1:0]    opcode,
    input  logic [hkv_pkg::KEY_W-1:0]   key_bytes,
    input  logic [hkv_pkg::LEN_W-1:0]   key_length,
    input  logic [hkv_pkg::VAL_W-1:0]   new_value,
    input  logic [hkv_pkg::VAL_W-1:0]   expected_value,
    input  logic [hkv_pkg::TIME_W-1:0]  expiry_time,
    input  logic [hkv_pkg::TIME_W-1:0]  now_us,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  status,
    output logic [hkv_pkg::VAL_W-1:0]   read_value,
    output logic [hkv_pkg::TIME_W-1:0]  read_expiry,
    output logic [hkv_pkg::CNT_W-1:0]   live_count,
    output logic [hkv_pkg::CNT_W-1:0]   evicted_count
);
    import hkv_pkg::*;

    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   q_valid;
    req_t   push_item;
    req_t   pop_item;

    hkv_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .key_bytes      (key_bytes),
        .key_length     (key_length),
        .new_value      (new_value),
        .expected_value (expected_value),
        .expiry_time    (expiry_time),
        .now_us         (now_us),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_item         (push_item)
    );

    hkv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_item  (pop_item)
    );

    hkv_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (pop_item),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .read_value    (read_value),
        .read_expiry   (read_expiry),
        .live_count    (live_count),
        .evicted_count (evicted_count)
    );

    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (live_count <= CNT_W'(SLOT_COUNT)))
        else $error("live count above slot count");

    a_evict_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && evicted_count != '0) |-> (status == ST_HIT))
        else $error("evicted entries without done status");

    a_read_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && read_value != '0) |-> (status == ST_HIT))
        else $error("value returned without hit");

    a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("front took a second item while hashing");

endmodule
